### design/pcicfg_pkg.sv
`default_nettype none

package pcicfg_pkg;

  // i/o port numbers
  localparam logic [15:0] ADDR_PORT  = 16'hCF8;
  localparam logic [15:0] DATA_PORT  = 16'hCFC;
  localparam logic [15:0] RESET_PORT = 16'hCF9;

  // configuration space geometry: 256 bytes per device
  localparam int unsigned SPACE_BYTES    = 256;
  localparam int unsigned WORDS_PER_DEV  = SPACE_BYTES / 4;
  localparam int unsigned REG_W          = $clog2(WORDS_PER_DEV);
  localparam int unsigned DEV_FIELD_W    = 5;
  localparam int unsigned FULL_IDX_W     = DEV_FIELD_W + REG_W;

  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] NARROW_READ = 32'h0000_00FF;
  localparam logic [2:0]  FULL_SIZE   = 3'd4;
  localparam logic [3:0]  RST_CODE_A  = 4'h6;
  localparam logic [3:0]  RST_CODE_B  = 4'hE;

  // register offsets that carry preset values
  localparam logic [REG_W-1:0] REG_ID    = REG_W'(0);
  localparam logic [REG_W-1:0] REG_CLASS = REG_W'(2);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] port;
    logic [31:0] value;
    logic [2:0]  access_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        reset_pending;
  } out_item_t;

  // reset contents of one configuration word
  function automatic logic [31:0] preset_word(logic [DEV_FIELD_W-1:0] dev,
                                              logic [REG_W-1:0]       offs);
    logic [31:0] word;
    word = '0;
    if (offs == REG_ID) begin
      case (dev)
        5'd0:    word = 32'h0001_1234;
        5'd1:    word = 32'h1111_1234;
        5'd2:    word = 32'h2222_1234;
        5'd3:    word = 32'h3333_1234;
        default: word = '0;
      endcase
    end else if (offs == REG_CLASS) begin
      case (dev)
        5'd0:    word = 32'h0600_0000;
        5'd1:    word = 32'h0101_0000;
        5'd2:    word = 32'h0300_0000;
        5'd3:    word = 32'h0C03_0000;
        default: word = '0;
      endcase
    end
    return word;
  endfunction

endpackage

`default_nettype wire

### design/pci_config_space_port_access.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------
// in       | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
// out      | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// One transfer per cycle in both directions while nothing stalls; every access gives one result
// in the cycle after acceptance, from the output register or the memory read port.
// After reset a clearing pass writes the DEVICE_COUNT*64 word memory, one word
// a cycle, so input stalls until the pass has written the last word.
// An input transfer is taken while the output register is empty or drained.
`default_nettype none

module pci_config_space_port_access
  import pcicfg_pkg::*;
#(
  parameter int unsigned DEVICE_COUNT = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned STORE_WORDS = DEVICE_COUNT * WORDS_PER_DEV;
  localparam int unsigned IDX_W       = $clog2(STORE_WORDS);

  // configuration store
  logic [31:0] store_mem [STORE_WORDS];

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic [31:0]       cfg_addr_q;
  logic              rst_flag_q, rst_flag_d;
  logic              out_valid_q, out_valid_d;
  logic              sel_mem_q, sel_mem_d;
  logic [31:0]       data_q, data_d;
  logic              pend_q, pend_d;
  logic [31:0]       rdata_q;

  logic                  accept;
  logic                  target_hit;
  logic [FULL_IDX_W-1:0] tgt_full;
  logic [FULL_IDX_W-1:0] clr_full;
  logic                  addr_we;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_idx;
  logic [31:0]           mem_wdata;

  // address decode of the latched configuration address
  assign tgt_full   = {cfg_addr_q[15:11], cfg_addr_q[7:2]};
  assign target_hit = cfg_addr_q[31] && (cfg_addr_q[23:16] == 8'h00) &&
                      ({1'b0, cfg_addr_q[15:11]} < 6'(DEVICE_COUNT));
  assign clr_full   = FULL_IDX_W'(clr_idx_q);

  assign accept     = (state_q == ST_RUN) && in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_RUN) || (out_valid_q && out_stall_i);

  // control, result and memory access
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    rst_flag_d  = rst_flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    sel_mem_d   = sel_mem_q;
    data_d      = data_q;
    pend_d      = pend_q;
    addr_we     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_idx     = tgt_full[IDX_W-1:0];
    mem_wdata   = in_item_i.value;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_idx   = clr_idx_q;
        mem_wdata = preset_word(clr_full[FULL_IDX_W-1:REG_W], clr_full[REG_W-1:0]);
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(STORE_WORDS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          out_valid_d = 1'b1;
          sel_mem_d   = 1'b0;
          data_d      = '0;
          case (in_item_i.operation)
            OP_READ: begin
              if (in_item_i.port == DATA_PORT && in_item_i.access_size == FULL_SIZE) begin
                if (target_hit) begin
                  mem_re    = 1'b1;
                  sel_mem_d = 1'b1;
                end else begin
                  data_d = ALL_ONES;
                end
              end else begin
                data_d = NARROW_READ;
              end
            end
            OP_WRITE: begin
              if (in_item_i.port == ADDR_PORT) begin
                addr_we = 1'b1;
              end else if (in_item_i.port == DATA_PORT) begin
                mem_we = target_hit;
              end else if (in_item_i.port == RESET_PORT) begin
                if ({in_item_i.value[3:1], 1'b0} == RST_CODE_A ||
                    {in_item_i.value[3:1], 1'b0} == RST_CODE_B) begin
                  rst_flag_d = 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              rst_flag_d = 1'b0;
            end
            default: begin
            end
          endcase
          pend_d = rst_flag_d;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      cfg_addr_q  <= '0;
      rst_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      rst_flag_q  <= rst_flag_d;
      out_valid_q <= out_valid_d;
      if (addr_we) begin
        cfg_addr_q <= in_item_i.value;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    sel_mem_q <= sel_mem_d;
    data_q    <= data_d;
    pend_q    <= pend_d;
  end

  // memory port: one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_idx] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_idx];
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_item_o.read_data     = sel_mem_q ? rdata_q : data_q;
  assign out_item_o.reset_pending = pend_q;

endmodule

`default_nettype wire

### tb/pci_config_space_port_access_test.sv
module pci_config_space_port_access_test
  import pcicfg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEV_COUNT     = 4;
  localparam int unsigned STORE_WORDS   = DEV_COUNT * WORDS_PER_DEV;
  localparam int unsigned DIRECTED_ROWS = 27;
  localparam int unsigned RANDOM_ITEMS  = 425;
  localparam int unsigned QUIET_ITEMS   = 60;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // operation code with no meaning, outside the package enum
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one row of the directed table
  typedef struct packed {
    in_item_t  access;
    bit        typed;
    out_item_t result;
  } access_row_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  // pacing controls shared by the driving processes
  bit pace_on     = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned accepted_count = 0;

  // shadow of the block state
  logic [31:0] shadow_addr;
  logic [31:0] shadow_space [0:STORE_WORDS-1];
  logic        shadow_reset_req;

  out_item_t awaited_results [$];

  access_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_READ,   ADDR_PORT,  32'h0000_0000, 3'd1}, 1'b1, '{NARROW_READ,   1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{ALL_ONES,      1'b0}},
    '{'{OP_WRITE,  ADDR_PORT,  32'h8000_0000, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{32'h0001_1234, 1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd2}, 1'b1, '{NARROW_READ,   1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd1}, 1'b1, '{NARROW_READ,   1'b0}},
    // function and low bits set, still device 0 register 0
    '{'{OP_WRITE,  ADDR_PORT,  32'h8000_0703, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{32'h0001_1234, 1'b0}},
    '{'{OP_WRITE,  ADDR_PORT,  32'h8000_1808, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{32'h0C03_0000, 1'b0}},
    // device out of range: write dropped, read all ones
    '{'{OP_WRITE,  ADDR_PORT,  32'h8000_2000, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_WRITE,  DATA_PORT,  32'hDEAD_BEEF, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{ALL_ONES,      1'b0}},
    // nonzero bus
    '{'{OP_WRITE,  ADDR_PORT,  32'h8001_0000, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b1, '{ALL_ONES,      1'b0}},
    // last register of device 1, byte write stores all 32 bits
    '{'{OP_WRITE,  ADDR_PORT,  32'h8000_08FC, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_WRITE,  DATA_PORT,  32'hFFFF_FFFF, 3'd1}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b0, '{32'h0,         1'b0}},
    '{'{OP_WRITE,  ADDR_PORT,  32'hFFFF_FFFF, 3'd4}, 1'b0, '{32'h0,         1'b0}},
    '{'{OP_READ,   DATA_PORT,  32'h0000_0000, 3'd4}, 1'b0, '{32'h0,         1'b0}},
    // reset port codes
    '{'{OP_WRITE,  RESET_PORT, 32'h0000_0002, 3'd1}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_WRITE,  RESET_PORT, 32'h0000_0006, 3'd1}, 1'b1, '{32'h0,         1'b1}},
    '{'{OP_WRITE,  RESET_PORT, 32'hFFFF_FFF1, 3'd1}, 1'b1, '{32'h0,         1'b1}},
    '{'{OP_CLEAR,  16'h0000,   32'h0000_0000, 3'd4}, 1'b1, '{32'h0,         1'b0}},
    '{'{OP_WRITE,  RESET_PORT, 32'h0000_000E, 3'd1}, 1'b1, '{32'h0,         1'b1}},
    '{'{OP_UNUSED, 16'hFFFF,   32'hFFFF_FFFF, 3'd4}, 1'b1, '{32'h0,         1'b1}},
    '{'{OP_CLEAR,  16'hFFFF,   32'hFFFF_FFFF, 3'd4}, 1'b0, '{32'h0,         1'b0}}
  };

  pci_config_space_port_access #(
    .DEVICE_COUNT(DEV_COUNT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #10 clk_i = ~clk_i;

  // advance the shadow state by one access and give its result
  function automatic out_item_t predict_access(input in_item_t acc);
    out_item_t   res;
    logic [10:0] word_idx;
    logic        hit;
    res      = '0;
    word_idx = {shadow_addr[15:11], shadow_addr[7:2]};
    hit      = shadow_addr[31] && (shadow_addr[23:16] == 8'h00) &&
               (shadow_addr[15:11] < DEV_COUNT);
    case (acc.operation)
      OP_READ: begin
        if (acc.port == DATA_PORT && acc.access_size == FULL_SIZE) begin
          res.read_data = hit ? shadow_space[word_idx] : ALL_ONES;
        end else begin
          res.read_data = NARROW_READ;
        end
      end
      OP_WRITE: begin
        if (acc.port == ADDR_PORT) begin
          shadow_addr = acc.value;
        end else if (acc.port == DATA_PORT) begin
          if (hit) shadow_space[word_idx] = acc.value;
        end else if (acc.port == RESET_PORT) begin
          if ({acc.value[3:1], 1'b0} == RST_CODE_A ||
              {acc.value[3:1], 1'b0} == RST_CODE_B) begin
            shadow_reset_req = 1'b1;
          end
        end
      end
      OP_CLEAR: shadow_reset_req = 1'b0;
      default: ;
    endcase
    res.reset_pending = shadow_reset_req;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // offer one access, with an optional gap first, and record its result
  task automatic offer_access(input in_item_t acc, input bit typed,
                              input out_item_t typed_res);
    out_item_t predicted;
    if (pace_on && !hold_active && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_item  <= acc;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = predict_access(acc);
    awaited_results.push_back(typed ? typed_res : predicted);
    accepted_count++;
  endtask

  // stimulus: directed table, then random sequences
  initial begin : stimulus
    in_item_t    acc;
    logic [31:0] cfg_addr;
    int unsigned pick;
    int unsigned burst;

    shadow_addr      = '0;
    shadow_reset_req = 1'b0;
    foreach (shadow_space[i]) shadow_space[i] = '0;
    shadow_space[0]   = 32'h0001_1234;
    shadow_space[2]   = 32'h0600_0000;
    shadow_space[64]  = 32'h1111_1234;
    shadow_space[66]  = 32'h0101_0000;
    shadow_space[128] = 32'h2222_1234;
    shadow_space[130] = 32'h0300_0000;
    shadow_space[192] = 32'h3333_1234;
    shadow_space[194] = 32'h0C03_0000;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < DIRECTED_ROWS; r++) begin
      offer_access(directed_rows[r].access, directed_rows[r].typed,
                   directed_rows[r].result);
    end

    // long output hold while input keeps coming
    hold_req = 1'b1;

    while (accepted_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if (accepted_count >= DIRECTED_ROWS + RANDOM_ITEMS - QUIET_ITEMS) pace_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // address latch followed by a burst of data transfers
        cfg_addr = $urandom();
        cfg_addr[31] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 7) != 0) cfg_addr[23:16] = 8'h00;
        if ($urandom_range(0, 7) != 0) cfg_addr[15:11] = 5'($urandom_range(0, DEV_COUNT - 1));
        acc = '{OP_WRITE, ADDR_PORT, cfg_addr, 3'($urandom_range(1, 4))};
        offer_access(acc, 1'b0, '0);
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          acc.port  = DATA_PORT;
          acc.value = $urandom();
          if ($urandom_range(0, 1) == 1) begin
            acc.operation   = OP_WRITE;
            acc.access_size = 3'($urandom_range(1, 4));
          end else begin
            acc.operation   = OP_READ;
            acc.access_size = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 4))
                                                          : FULL_SIZE;
          end
          offer_access(acc, 1'b0, '0);
        end
      end else if (pick == 7) begin
        // reset request traffic
        acc = '{OP_WRITE, RESET_PORT, $urandom(), 3'($urandom_range(1, 4))};
        case ($urandom_range(0, 3))
          0: acc.operation = OP_CLEAR;
          1: acc.value[3:1] = 3'b011;
          2: acc.value[3:1] = 3'b111;
          default: ;
        endcase
        offer_access(acc, 1'b0, '0);
      end else begin
        // noise on any port
        acc.operation   = 2'($urandom_range(0, 2));
        acc.value       = $urandom();
        acc.access_size = 3'($urandom_range(1, 4));
        case ($urandom_range(0, 3))
          0: acc.port = ADDR_PORT;
          1: acc.port = DATA_PORT;
          2: acc.port = RESET_PORT;
          default: acc.port = 16'($urandom());
        endcase
        offer_access(acc, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // output stall bursts, plus one long hold
  initial begin : result_pacing
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall   <= 1'b1;
        hold_active = 1'b1;
        held        = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk_i);
          held++;
        end
        out_stall   <= 1'b0;
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else if (pace_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // compare each output transfer with the oldest awaited result
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer data %h flag %b",
                                  out_item.read_data, out_item.reset_pending));
      end else begin
        want = awaited_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data %h, want %h",
                                    out_item.read_data, want.read_data));
        end
        if (out_item.reset_pending !== want.reset_pending) begin
          report_mismatch($sformatf("reset_pending %b, want %b",
                                    out_item.reset_pending, want.reset_pending));
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin : cycle_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
